@@ src/bpc_pkg.sv @@
// Shared types, register codes, constants and helpers for the pressure compensation block.
package bpc_pkg;

  localparam int DataW      = 32;
  localparam int QueueDepth = 4;

  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;
  localparam logic [2:0] REG_OSS     = 3'd5;

  localparam logic signed [31:0] C_B6_OFFSET = 32'sd4000;
  localparam logic [31:0]        C_B7_SCALE  = 32'd50000;
  localparam logic signed [31:0] C_B4_OFFSET = 32'sd32768;
  localparam logic signed [31:0] C_P_K1      = 32'sd3038;
  localparam logic signed [31:0] C_P_K2      = -32'sd7357;
  localparam logic signed [31:0] C_P_K3      = 32'sd3791;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               divide_error;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic [1:0]         oss;
  } cal_t;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] den;
    logic               den_zero;
    logic [23:0]        raw_pressure;
  } entry_t;

  // Signed division by 2**k, truncating toward zero.
  function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] a,
                                                 input int unsigned k);
    logic [31:0]        bias;
    logic signed [31:0] sum;
    bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    sum  = a + $signed(bias);
    return sum >>> k;
  endfunction

endpackage

@@ src/bpc_front.sv @@
// Input stage: takes readings, forms the first temperature term and the temperature divisor.
module bpc_front import bpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  input  cal_t     cal,
  input  logic     q_full,
  output logic     q_push,
  output entry_t   q_data
);

  logic               vld;
  logic signed [31:0] prod;
  logic [23:0]        raw_p;
  logic signed [31:0] ut;
  logic signed [31:0] diff;
  logic               take;

  assign full   = vld && q_full;
  assign take   = push && !full;
  assign q_push = vld && !q_full;

  assign ut   = {{16{in_item.raw_temperature[15]}}, in_item.raw_temperature};
  assign diff = ut - $signed({16'b0, cal.ac6});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!vld || !q_full) begin
      vld <= take;
    end
    if (take) begin
      prod  <= diff * $signed({16'b0, cal.ac5});
      raw_p <= in_item.raw_pressure;
    end
  end

  always_comb begin
    q_data.x1           = sdiv_p2(prod, 15);
    q_data.den          = q_data.x1 + {{16{cal.md[15]}}, cal.md};
    q_data.den_zero     = (q_data.den == 32'sd0);
    q_data.raw_pressure = raw_p;
  end

endmodule

@@ src/bpc_queue.sv @@
// Small register queue between the input stage and the compute pipeline.
module bpc_queue import bpc_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t wdata,
  output logic   qfull,
  input  logic   rd,
  output logic   qempty,
  output entry_t rdata
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  entry_t            mem [Depth];
  logic [PtrW-1:0]   wp;
  logic [PtrW-1:0]   rp;
  logic [CntW-1:0]   cnt;

  assign qfull  = (cnt == CntW'(Depth));
  assign qempty = (cnt == '0);
  assign rdata  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + PtrW'(1);
      end
      if (rd) begin
        rp <= rp + PtrW'(1);
      end
      if (wr && !rd) begin
        cnt <= cnt + CntW'(1);
      end else if (rd && !wr) begin
        cnt <= cnt - CntW'(1);
      end
    end
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

endmodule

@@ src/bpc_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage, with a sideband.
module bpc_div #(
  parameter int W  = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  input  logic [SW-1:0] side,
  output logic          out_vld,
  output logic [W-1:0]  quo,
  output logic [SW-1:0] out_side
);

  logic [W-1:0]  s_num  [W+1];
  logic [W-1:0]  s_rem  [W+1];
  logic [W-1:0]  s_den  [W+1];
  logic [SW-1:0] s_side [W+1];
  logic          s_vld  [W+1];

  assign s_num[0]  = num;
  assign s_rem[0]  = '0;
  assign s_den[0]  = den;
  assign s_side[0] = side;
  assign s_vld[0]  = in_vld;

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    assign trial = {s_rem[i], s_num[i][W-1]};
    assign diff  = trial - {1'b0, s_den[i]};
    assign ge    = (trial >= {1'b0, s_den[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        s_vld[i+1] <= 1'b0;
      end else if (en) begin
        s_vld[i+1] <= s_vld[i];
      end
      if (en) begin
        s_rem[i+1]  <= ge ? diff[W-1:0] : trial[W-1:0];
        s_num[i+1]  <= {s_num[i][W-2:0], ge};
        s_den[i+1]  <= s_den[i];
        s_side[i+1] <= s_side[i];
      end
    end
  end

  assign out_vld  = s_vld[W];
  assign quo      = s_num[W];
  assign out_side = s_side[W];

endmodule

@@ src/bpc_back.sv @@
// Compute pipeline: temperature division, pressure terms and division, correction, output reg.
module bpc_back import bpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cal_t      cal,
  input  logic      q_empty,
  input  entry_t    q_data,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  localparam int Side1W = 32 + 24 + 2;
  localparam int Side2W = 16 + 2;

  logic adv;
  logic o_vld;

  assign adv   = !o_vld || pop;
  assign q_pop = adv && !q_empty;
  assign empty = !o_vld;

  // temperature division: (MC * 2048) / (X1 + MD) on magnitudes
  logic signed [31:0] nm1;
  logic [31:0]        num1_mag;
  logic [31:0]        den1_mag;
  logic               neg1;
  logic               v1;
  logic [31:0]        q1;
  logic [Side1W-1:0]  side1_o;

  assign nm1      = {{5{cal.mc[15]}}, cal.mc, 11'b0};
  assign num1_mag = nm1[31] ? 32'(-nm1) : 32'(nm1);
  assign den1_mag = q_data.den[31] ? 32'(-q_data.den) : 32'(q_data.den);
  assign neg1     = nm1[31] ^ q_data.den[31];

  bpc_div #(.W(DataW), .SW(Side1W)) u_div_t (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (!q_empty),
    .num      (num1_mag),
    .den      (den1_mag),
    .side     ({q_data.x1, q_data.raw_pressure, q_data.den_zero, neg1}),
    .out_vld  (v1),
    .quo      (q1),
    .out_side (side1_o)
  );

  // stage A
  logic signed [31:0] x1_o;
  logic [23:0]        rp_o;
  logic               dz_o;
  logic               neg_o;
  logic signed [31:0] x2_t;
  logic signed [31:0] b5;
  logic signed [31:0] tq;
  logic signed [15:0] tsat;

  assign {x1_o, rp_o, dz_o, neg_o} = side1_o;
  assign x2_t = neg_o ? -$signed(q1) : $signed(q1);
  assign b5   = x1_o + x2_t;
  assign tq   = sdiv_p2(b5 + 32'sd8, 4);

  always_comb begin
    if (tq > 32'sd32767) begin
      tsat = 16'sh7fff;
    end else if (tq < -32'sd32768) begin
      tsat = -16'sh8000;
    end else begin
      tsat = tq[15:0];
    end
  end

  logic               a_vld, b_vld, c_vld, d_vld, e_vld, f_vld, g_vld;
  logic               a_err, b_err, c_err, d_err, e_err, f_err, g_err;
  logic signed [15:0] a_t, b_t, c_t, d_t, e_t, f_t, g_t;
  logic [23:0]        a_rp, b_rp, c_rp, d_rp, e_rp;
  logic signed [31:0] a_b6;
  logic signed [31:0] b_sqp, b_m2, b_m3;
  logic signed [31:0] c_sq, c_x2, c_x1;
  logic signed [31:0] d_mb2, d_mb1, d_x2, d_x1;
  logic signed [31:0] e_b3, e_w;
  logic [31:0]        f_b4p, f_diff;
  logic [31:0]        g_b4, g_b7;

  // stage E terms, and the stage F raw pressure term
  logic signed [31:0] x3_e;
  logic signed [31:0] s_e;
  logic signed [31:0] sh_e;
  logic signed [31:0] y_e;
  logic [31:0]        up_f;

  assign x3_e = sdiv_p2(d_mb2, 11) + d_x2;
  assign s_e  = ($signed({{16{cal.ac1[15]}}, cal.ac1}) <<< 2) + x3_e;
  assign sh_e = $signed(32'(s_e) << cal.oss);
  assign y_e  = sdiv_p2(d_x1 + sdiv_p2(d_mb1, 16) + 32'sd2, 2);
  assign up_f = {8'b0, e_rp >> (4'd8 - {2'b0, cal.oss})};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= v1;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
      f_vld <= e_vld;
      g_vld <= f_vld;
    end
    if (adv) begin
      a_err <= dz_o;
      a_t   <= tsat;
      a_rp  <= rp_o;
      a_b6  <= b5 - C_B6_OFFSET;

      b_err <= a_err;
      b_t   <= a_t;
      b_rp  <= a_rp;
      b_sqp <= a_b6 * a_b6;
      b_m2  <= a_b6 * 32'(cal.ac2);
      b_m3  <= a_b6 * 32'(cal.ac3);

      c_err <= b_err;
      c_t   <= b_t;
      c_rp  <= b_rp;
      c_sq  <= sdiv_p2(b_sqp, 12);
      c_x2  <= sdiv_p2(b_m2, 11);
      c_x1  <= sdiv_p2(b_m3, 13);

      d_err <= c_err;
      d_t   <= c_t;
      d_rp  <= c_rp;
      d_mb2 <= c_sq * 32'(cal.b2);
      d_mb1 <= c_sq * 32'(cal.b1);
      d_x2  <= c_x2;
      d_x1  <= c_x1;

      e_err <= d_err;
      e_t   <= d_t;
      e_rp  <= d_rp;
      e_b3  <= sdiv_p2(sh_e + 32'sd2, 2);
      e_w   <= y_e + C_B4_OFFSET;

      f_err  <= e_err;
      f_t    <= e_t;
      f_b4p  <= {16'b0, cal.ac4} * 32'(e_w);
      f_diff <= up_f - 32'(e_b3);

      g_err <= f_err || (f_b4p[31:15] == 17'd0);
      g_t   <= f_t;
      g_b4  <= {15'b0, f_b4p[31:15]};
      g_b7  <= f_diff * (C_B7_SCALE >> cal.oss);
    end
  end

  // pressure division: B7 * 2 / B4, or (B7 / B4) * 2 when B7 has its top bit set
  logic              dbl_g;
  logic              v2;
  logic [31:0]       q2;
  logic [Side2W-1:0] side2_o;

  assign dbl_g = g_b7[31];

  bpc_div #(.W(DataW), .SW(Side2W)) u_div_p (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (g_vld),
    .num      (dbl_g ? g_b7 : {g_b7[30:0], 1'b0}),
    .den      (g_b4),
    .side     ({g_t, g_err, dbl_g}),
    .out_vld  (v2),
    .quo      (q2),
    .out_side (side2_o)
  );

  logic signed [15:0] t2_o;
  logic               err2_o;
  logic               dbl_o;
  logic signed [31:0] pu;

  assign {t2_o, err2_o, dbl_o} = side2_o;
  assign pu = dbl_o ? $signed({q2[30:0], 1'b0}) : $signed(q2);

  logic               h_vld, i_vld, j_vld;
  logic               h_err, i_err, j_err;
  logic signed [15:0] h_t, i_t, j_t;
  logic signed [31:0] h_p, h_pd;
  logic signed [31:0] i_p, i_sq, i_m2;
  logic signed [31:0] j_p, j_m3, j_x2;
  logic signed [31:0] p_fin;

  assign p_fin = j_p + sdiv_p2(sdiv_p2(j_m3, 16) + j_x2 + C_P_K3, 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
      i_vld <= 1'b0;
      j_vld <= 1'b0;
      o_vld <= 1'b0;
    end else if (adv) begin
      h_vld <= v2;
      i_vld <= h_vld;
      j_vld <= i_vld;
      o_vld <= j_vld;
    end
    if (adv) begin
      h_err <= err2_o;
      h_t   <= t2_o;
      h_p   <= pu;
      h_pd  <= sdiv_p2(pu, 8);

      i_err <= h_err;
      i_t   <= h_t;
      i_p   <= h_p;
      i_sq  <= h_pd * h_pd;
      i_m2  <= h_p * C_P_K2;

      j_err <= i_err;
      j_t   <= i_t;
      j_p   <= i_p;
      j_m3  <= i_sq * C_P_K1;
      j_x2  <= sdiv_p2(i_m2, 16);

      out_item.divide_error       <= j_err;
      out_item.temperature_tenths <= j_err ? 16'sd0 : j_t;
      out_item.pressure_pa        <= j_err ? 32'sd0 : p_fin;
    end
  end

endmodule

@@ src/barometric_pressure_compensation_top.sv @@
// Top level of the barometric pressure compensation block.
//
// Each transaction on the input queue carries one raw temperature word and one
// raw 24-bit pressure reading; each transaction on the result queue returns the
// compensated temperature in tenths of a degree Celsius (saturated to 16 bits),
// the pressure in pascals, and a divide error flag that is set, with both
// values zero, when the temperature divisor (X1 + MD) or B4 is zero. Results
// leave in the order the readings came in, one per reading. The block is fully
// pipelined: a new reading may be pushed every cycle while full is low and one
// result may be popped every cycle. From the push that is taken to the head of
// the result queue a reading passes the input stage, the small queue, the two
// 32-stage dividers (one quotient bit per stage), ten arithmetic stages of at
// most one multiplier level each and the output register. While a result waits
// and pop is low the compute pipeline holds as a whole; the input stage and
// its queue keep taking readings until the queue is full and the input stage
// holds a reading, then full rises. Calibration registers are written through
// the cfg channel, which is always ready; write them only while no reading is
// in flight.
module barometric_pressure_compensation_top import bpc_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] cal_ac1_ac2;
  logic [31:0] cal_ac3_ac4;
  logic [31:0] cal_ac5_ac6;
  logic [31:0] cal_b1_b2;
  logic [31:0] cal_mc_md;
  logic [1:0]  oversampling;
  cal_t        cal;

  assign cfg_ready = 1'b1;

  // Take register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac1_ac2  <= '0;
      cal_ac3_ac4  <= '0;
      cal_ac5_ac6  <= '0;
      cal_b1_b2    <= '0;
      cal_mc_md    <= '0;
      oversampling <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AC1_AC2: cal_ac1_ac2  <= cfg_data;
        REG_AC3_AC4: cal_ac3_ac4  <= cfg_data;
        REG_AC5_AC6: cal_ac5_ac6  <= cfg_data;
        REG_B1_B2:   cal_b1_b2    <= cfg_data;
        REG_MC_MD:   cal_mc_md    <= cfg_data;
        REG_OSS:     oversampling <= cfg_data[1:0];
        default:     ;
      endcase
    end
  end

  // Unpack the coefficient fields once for both halves of the design.
  always_comb begin
    cal.ac1 = cal_ac1_ac2[31:16];
    cal.ac2 = cal_ac1_ac2[15:0];
    cal.ac3 = cal_ac3_ac4[31:16];
    cal.ac4 = cal_ac3_ac4[15:0];
    cal.ac5 = cal_ac5_ac6[31:16];
    cal.ac6 = cal_ac5_ac6[15:0];
    cal.b1  = cal_b1_b2[31:16];
    cal.b2  = cal_b1_b2[15:0];
    cal.mc  = cal_mc_md[31:16];
    cal.md  = cal_mc_md[15:0];
    cal.oss = oversampling;
  end

  logic   q_wr;
  logic   q_rd;
  logic   q_full;
  logic   q_empty;
  entry_t q_wdata;
  entry_t q_rdata;

  bpc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .cal     (cal),
    .q_full  (q_full),
    .q_push  (q_wr),
    .q_data  (q_wdata)
  );

  bpc_queue #(.Depth(QDepth)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wdata  (q_wdata),
    .qfull  (q_full),
    .rd     (q_rd),
    .qempty (q_empty),
    .rdata  (q_rdata)
  );

  bpc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cal      (cal),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

@@ bench/barometric_pressure_compensation_top_test.sv @@
// Testbench for the barometric pressure compensation block: predicted results against the queue outputs.
module barometric_pressure_compensation_top_test;
  import bpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Calibration image kept by the bench, written alongside every register write.
  typedef struct {
    logic [31:0] ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mc_md;
    logic [1:0]  oss;
  } cal_image_t;

  // Truncating signed division with the most-negative-by-minus-one wrap.
  function automatic logic signed [31:0] div_trunc(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    logic [31:0] ua, ub, q;
    if (b == -32'sd1) return -a;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q  = ua / ub;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  // Compute the compensated reading for one raw sample.
  function automatic out_item_t compensate(cal_image_t c, in_item_t s);
    logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut, up;
    logic signed [31:0] x1, x2, x3, b3, b5, b6, den, t, p, sq;
    logic [31:0] ac4, b4, b7, pu;
    logic [63:0] wide;
    out_item_t r;
    ac1 = {{16{c.ac1_ac2[31]}}, c.ac1_ac2[31:16]};
    ac2 = {{16{c.ac1_ac2[15]}}, c.ac1_ac2[15:0]};
    ac3 = {{16{c.ac3_ac4[31]}}, c.ac3_ac4[31:16]};
    ac4 = {16'd0, c.ac3_ac4[15:0]};
    ac5 = {16'd0, c.ac5_ac6[31:16]};
    ac6 = {16'd0, c.ac5_ac6[15:0]};
    b1  = {{16{c.b1_b2[31]}}, c.b1_b2[31:16]};
    b2  = {{16{c.b1_b2[15]}}, c.b1_b2[15:0]};
    mc  = {{16{c.mc_md[31]}}, c.mc_md[31:16]};
    md  = {{16{c.mc_md[15]}}, c.mc_md[15:0]};
    ut  = {{16{s.raw_temperature[15]}}, s.raw_temperature};
    up  = {8'd0, s.raw_pressure} >> (8 - c.oss);
    r = '0;
    r.divide_error = 1'b1;
    x1  = div_trunc((ut - ac6) * ac5, 32768);
    den = x1 + md;
    if (den == 0) return r;
    x2 = div_trunc(mc * 2048, den);
    b5 = x1 + x2;
    t  = div_trunc(b5 + 8, 16);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    b6 = b5 - 4000;
    sq = div_trunc(b6 * b6, 4096);
    x1 = div_trunc(b2 * sq, 2048);
    x2 = div_trunc(ac2 * b6, 2048);
    x3 = x1 + x2;
    b3 = div_trunc(((ac1 * 4 + x3) << c.oss) + 2, 4);
    x1 = div_trunc(ac3 * b6, 8192);
    x2 = div_trunc(b1 * sq, 65536);
    x3 = div_trunc(x1 + x2 + 2, 4);
    wide = {32'd0, ac4} * {32'd0, x3 + 32'sd32768};
    b4 = wide[31:0] / 32'd32768;
    if (b4 == 0) return r;
    b7 = (up - b3) * (32'd50000 >> c.oss);
    if (b7 < 32'h8000_0000) pu = (b7 * 2) / b4;
    else pu = (b7 / b4) * 2;
    p  = pu;
    x1 = div_trunc(p, 256) * div_trunc(p, 256);
    x1 = div_trunc(x1 * 3038, 65536);
    x2 = div_trunc(-32'sd7357 * p, 65536);
    p  = p + div_trunc(x1 + x2 + 3791, 16);
    r.temperature_tenths = t[15:0];
    r.pressure_pa = p;
    r.divide_error = 1'b0;
    return r;
  endfunction

  class compensation_scoreboard;
    out_item_t pending[$];
    int mismatches;
    function void note_reading(cal_image_t c, in_item_t s);
      pending.push_back(compensate(c, s));
    endfunction
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  in_item_t in_item = '0;
  logic full, empty, cfg_ready;
  out_item_t out_item;

  compensation_scoreboard board = new();
  cal_image_t cal = '{default: '0};
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  barometric_pressure_compensation_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Sample the result queue at each edge; draw the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) board.check_result(out_item);
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Write one calibration register and mirror it in the bench image.
  task automatic write_register(logic [2:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_AC1_AC2: cal.ac1_ac2 = value;
      REG_AC3_AC4: cal.ac3_ac4 = value;
      REG_AC5_AC6: cal.ac5_ac6 = value;
      REG_B1_B2:   cal.b1_b2   = value;
      REG_MC_MD:   cal.mc_md   = value;
      REG_OSS:     cal.oss     = value[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one reading, holding it until the input queue takes it; push stays
  // high after the transaction so back-to-back readings leave no gap.
  task automatic send_reading(logic [15:0] t_raw, logic [23:0] p_raw);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= '{raw_temperature: t_raw, raw_pressure: p_raw};
    do @(posedge clk); while (full);
    board.note_reading(cal, '{raw_temperature: t_raw, raw_pressure: p_raw});
  endtask

  // Drop push and drain in-flight readings before touching calibration.
  task automatic wait_idle();
    push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Load a full calibration set: typical datasheet-like values with jitter, or raw noise.
  task automatic load_calibration(bit noisy, logic [1:0] oss);
    if (noisy) begin
      write_register(REG_AC1_AC2, $urandom());
      write_register(REG_AC3_AC4, $urandom());
      write_register(REG_AC5_AC6, $urandom());
      write_register(REG_B1_B2, $urandom());
      write_register(REG_MC_MD, $urandom());
    end else begin
      write_register(REG_AC1_AC2, {16'd408 + 16'($urandom_range(8000)),
                                   -16'sd72 - 16'($urandom_range(100))});
      write_register(REG_AC3_AC4, {-16'sd14383 + 16'($urandom_range(2000)),
                                   16'd32741 + 16'($urandom_range(1000))});
      write_register(REG_AC5_AC6, {16'd32757 - 16'($urandom_range(10000)),
                                   16'd23153 + 16'($urandom_range(3000))});
      write_register(REG_B1_B2, {16'd6190 + 16'($urandom_range(500)),
                                 16'd4 + 16'($urandom_range(40))});
      write_register(REG_MC_MD, {-16'sd8711 + 16'($urandom_range(1000)),
                                 16'd2868 + 16'($urandom_range(200))});
    end
    // Upper data bits are junk on purpose: the block keeps the low two only.
    write_register(REG_OSS, {30'($urandom_range(32'h3fff_ffff)), oss});
  endtask

  // Random readings, mostly near the calibrated operating point.
  task automatic random_readings(int count);
    repeat (count) begin
      if ($urandom_range(3) != 0)
        send_reading(16'd27898 + 16'($urandom_range(4000)) - 16'd2000,
                     24'h5d0000 + 24'($urandom_range(24'h3fffff)));
      else send_reading(16'($urandom()), 24'($urandom()));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes with all-zero calibration (temperature divisor zero).
    send_reading(16'h0000, 24'h000000);
    send_reading(16'hffff, 24'hffffff);
    wait_idle();
    // X1 = 0 with MD = 0 -> zero divisor; then MD = 5 with AC4 = 0 -> B4 zero.
    write_register(REG_MC_MD, 32'h0001_0000);
    write_register(REG_AC5_AC6, 32'h0000_0000);
    send_reading(16'h1234, 24'h123456);
    wait_idle();
    write_register(REG_MC_MD, 32'h0001_0005);
    send_reading(16'h8000, 24'h800000);
    wait_idle();
    // Extreme registers: saturates temperature and drives wrap cases.
    write_register(REG_AC1_AC2, 32'h8000_7fff);
    write_register(REG_AC3_AC4, 32'h7fff_ffff);
    write_register(REG_AC5_AC6, 32'hffff_0000);
    write_register(REG_B1_B2, 32'h7fff_8000);
    write_register(REG_MC_MD, 32'h7fff_0001);
    write_register(REG_OSS, 32'hffff_ffff);
    send_reading(16'h7fff, 24'hffffff);
    send_reading(16'h8000, 24'h000000);
    send_reading(16'h0000, 24'h7fffff);
    wait_idle();
    // Divide by minus one path: X1 + MD = -1.
    write_register(REG_MC_MD, 32'h8000_ffff);
    send_reading(16'h0000, 24'h000001);
    wait_idle();
    for (int o = 0; o < 4; o++) begin
      load_calibration(1'b0, o[1:0]);
      send_reading(16'd27898, 24'h5d2300);
      send_reading(16'hffff, 24'h000000);
      wait_idle();
    end

    // Random phases: no idling, sender idle, receiver stall, both.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      load_calibration(ph == 5, ph[1:0]);
      random_readings(80);
      wait_idle();
    end

    if (board.mismatches == 0) $display("PASS barometric_pressure_compensation_top");
    else $display("FAIL barometric_pressure_compensation_top");
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("FAIL barometric_pressure_compensation_top");
    $finish;
  end
endmodule
